FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk and held off
// during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ILC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ILC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ilc_pkg.sv
// ---------------------------------------------------------------------------
// Indent level checker package
// Widths, byte codes, register indexes and a saturating helper.
// ---------------------------------------------------------------------------
package ilc_pkg;

    localparam int STACK_DEPTH  = 32;
    localparam int INDENT_WIDTH = 10;
    localparam int LINE_WIDTH   = 20;
    localparam int CFG_WIDTH    = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int STACK_IDX_W  = $clog2(STACK_DEPTH);
    localparam int COUNT_W      = $clog2(STACK_DEPTH + 1);

    localparam logic [INDENT_WIDTH-1:0] IND_MAX  = {INDENT_WIDTH{1'b1}};
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] SPACE_BYTE   = 8'd32;
    localparam logic [7:0] TAB_BYTE     = 8'd9;
    localparam logic [7:0] COLON_BYTE   = 8'd58;

    localparam logic [CFG_IDX_W-1:0] REG_INDENT_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH   = 1'd1;

    localparam logic [CFG_WIDTH-1:0] CFG_RESET_VALUE = 5'd4;

    // Adds a register value to an indent and clips at the largest indent.
    function automatic logic [INDENT_WIDTH-1:0] sat_ind(
        input logic [INDENT_WIDTH-1:0] a,
        input logic [CFG_WIDTH-1:0]    b
    );
        logic [INDENT_WIDTH:0] sum;
        sum = {1'b0, a} + (INDENT_WIDTH + 1)'(b);
        return sum[INDENT_WIDTH] ? IND_MAX : sum[INDENT_WIDTH-1:0];
    endfunction

endpackage

FILE: design/indent_level_checker_top.sv
// ---------------------------------------------------------------------------
// Indent level checker
// Checks Python-style indentation of a byte stream against a level stack.
// ---------------------------------------------------------------------------
// Each accepted request carries one byte of text. Ordinary bytes, and the
// newline of a line holding only blanks, leave the checker idle and ready
// for the next byte. The end of a line with content stalls input while it
// runs through S_POP, where the stack is unwound one entry per cycle through
// a single shared compare and subtract unit until the top level is found in
// place, and then S_DECIDE, which makes the error check and push decision. A
// result that finds the output register still full waits there until it is
// taken. The final byte returns the line and stack state to reset, registers
// excepted; the stack needs no clearing pass as only live entries are read.
`include "assert_macros.svh"

module indent_level_checker_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ilc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ilc_pkg::CFG_WIDTH-1:0]     cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        text_byte,
    input  logic                              final_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ilc_pkg::LINE_WIDTH-1:0]    line_number,
    output logic [ilc_pkg::INDENT_WIDTH-1:0]  expected_indent,
    output logic [ilc_pkg::INDENT_WIDTH-1:0]  found_indent
);
    import ilc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DECIDE
    } state_t;

    state_t                   state_reg, state_next;
    logic [CFG_WIDTH-1:0]     indent_step_reg, indent_step_next;
    logic [CFG_WIDTH-1:0]     tab_width_reg, tab_width_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic [LINE_WIDTH-1:0]    line_reg, line_next;
    logic [INDENT_WIDTH-1:0]  width_reg, width_next;
    logic                     blanks_reg, blanks_next;
    logic                     content_reg, content_next;
    logic                     colon_reg, colon_next;
    logic                     fin_reg, fin_next;
    logic                     out_valid_reg, out_valid_next;
    logic [LINE_WIDTH-1:0]    out_line_reg, out_line_next;
    logic [INDENT_WIDTH-1:0]  out_exp_reg, out_exp_next;
    logic [INDENT_WIDTH-1:0]  out_found_reg, out_found_next;

    logic [INDENT_WIDTH-1:0]  stack_mem [STACK_DEPTH];

    logic                     accept;
    logic                     is_space, is_tab, is_blank, is_newline;
    logic [INDENT_WIDTH-1:0]  width_upd;
    logic                     content_upd;
    logic                     line_ends;
    logic                     end_content;
    logic [LINE_WIDTH-1:0]    line_inc;
    logic [STACK_IDX_W-1:0]   top_idx;
    logic [INDENT_WIDTH-1:0]  top_level;
    logic [INDENT_WIDTH:0]    diff;
    logic                     ind_lt_top, ind_gt_top;
    logic                     indent_error;
    logic                     decide_go;
    logic                     push_en;
    logic [INDENT_WIDTH-1:0]  push_value;

    assign in_stall        = (state_reg != S_IDLE);
    assign accept          = in_valid && !in_stall;
    assign out_valid       = out_valid_reg;
    assign line_number     = out_line_reg;
    assign expected_indent = out_exp_reg;
    assign found_indent    = out_found_reg;

    // Byte classification and the line state that the byte would leave.
    assign is_space    = (text_byte == SPACE_BYTE);
    assign is_tab      = (text_byte == TAB_BYTE);
    assign is_blank    = is_space || is_tab;
    assign is_newline  = (text_byte == NEWLINE_BYTE);
    assign width_upd   = (blanks_reg && is_space) ? sat_ind(width_reg, CFG_WIDTH'(1)) :
                         (blanks_reg && is_tab)   ? sat_ind(width_reg, tab_width_reg) :
                                                    width_reg;
    assign content_upd = content_reg || !is_blank;
    assign line_ends   = is_newline || final_byte;
    assign end_content = is_newline ? content_reg : content_upd;
    assign line_inc    = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;

    // The shared unit: one subtraction of the top level from the line indent.
    assign top_idx      = STACK_IDX_W'(count_reg - 1'b1);
    assign top_level    = (top_idx == '0) ? '0 : stack_mem[top_idx];
    assign diff         = {1'b0, width_reg} - {1'b0, top_level};
    assign ind_lt_top   = diff[INDENT_WIDTH];
    assign ind_gt_top   = !diff[INDENT_WIDTH] && (diff != '0);
    assign indent_error = ind_gt_top && (diff != (INDENT_WIDTH + 1)'(indent_step_reg));
    assign decide_go    = !(indent_error && out_valid_reg && out_stall);
    assign push_en      = (state_reg == S_DECIDE) && decide_go && (colon_reg || ind_gt_top)
                          && (count_reg < COUNT_W'(STACK_DEPTH));
    assign push_value   = colon_reg ? sat_ind(width_reg, indent_step_reg) : width_reg;

    always_comb
    begin
        state_next       = state_reg;
        indent_step_next = indent_step_reg;
        tab_width_next   = tab_width_reg;
        count_next       = count_reg;
        line_next        = line_reg;
        width_next       = width_reg;
        blanks_next      = blanks_reg;
        content_next     = content_reg;
        colon_next       = colon_reg;
        fin_next         = fin_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_line_next    = out_line_reg;
        out_exp_next     = out_exp_reg;
        out_found_next   = out_found_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INDENT_STEP: indent_step_next = cfg_data;
                REG_TAB_WIDTH:   tab_width_next   = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!is_newline)
                    begin
                        width_next   = width_upd;
                        blanks_next  = blanks_reg && is_blank;
                        content_next = content_upd;
                        colon_next   = (text_byte == COLON_BYTE);
                    end
                    if (line_ends)
                    begin
                        line_next = line_inc;
                        fin_next  = final_byte;
                        if (end_content)
                        begin
                            state_next = S_POP;
                        end
                        else
                        begin
                            width_next   = '0;
                            blanks_next  = 1'b1;
                            content_next = 1'b0;
                            colon_next   = 1'b0;
                            if (final_byte)
                            begin
                                count_next = COUNT_W'(1);
                                line_next  = '0;
                            end
                        end
                    end
                end
            end
            S_POP:
            begin
                // One level comes off per cycle while the line sits shallower and levels remain above the base.
                if ((count_reg > COUNT_W'(1)) && ind_lt_top)
                    count_next = count_reg - 1'b1;
                else
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (decide_go)
                begin
                    if (indent_error)
                    begin
                        out_valid_next = 1'b1;
                        out_line_next  = line_reg;
                        out_exp_next   = sat_ind(top_level, indent_step_reg);
                        out_found_next = width_reg;
                    end
                    if (push_en)
                        count_next = count_reg + 1'b1;
                    width_next   = '0;
                    blanks_next  = 1'b1;
                    content_next = 1'b0;
                    colon_next   = 1'b0;
                    if (fin_reg)
                    begin
                        count_next = COUNT_W'(1);
                        line_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            indent_step_reg <= CFG_RESET_VALUE;
            tab_width_reg   <= CFG_RESET_VALUE;
            count_reg       <= COUNT_W'(1);
            line_reg        <= '0;
            width_reg       <= '0;
            blanks_reg      <= 1'b1;
            content_reg     <= 1'b0;
            colon_reg       <= 1'b0;
            fin_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            indent_step_reg <= indent_step_next;
            tab_width_reg   <= tab_width_next;
            count_reg       <= count_next;
            line_reg        <= line_next;
            width_reg       <= width_next;
            blanks_reg      <= blanks_next;
            content_reg     <= content_next;
            colon_reg       <= colon_next;
            fin_reg         <= fin_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_line_reg  <= out_line_next;
        out_exp_reg   <= out_exp_next;
        out_found_reg <= out_found_next;
        if (push_en)
            stack_mem[count_reg[STACK_IDX_W-1:0]] <= push_value;
    end

    `ILC_ASSERT(a_count_range, (count_reg != '0) && (count_reg <= COUNT_W'(STACK_DEPTH)), "stack count out of range")
    `ILC_ASSERT_NEXT(a_pop_only_down, state_reg == S_POP, count_reg <= $past(count_reg), "stack grew while popping")
    `ILC_ASSERT_NEXT(a_final_clears, (state_reg == S_DECIDE) && decide_go && fin_reg, (count_reg == COUNT_W'(1)) && (line_reg == '0), "state not cleared after final byte")
    `ILC_ASSERT(a_result_source, $rose(out_valid_reg) |-> $past(state_reg == S_DECIDE), "result raised outside the decision step")

endmodule
